FILE: hdl/dsh_pkg.sv
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared types and constants of the four-channel DShot transmitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsh_pkg;

    localparam int TICK_W     = 16;   // width of the bit cell timers
    localparam int GAP_W      = 24;   // width of the frame gap timer
    localparam int CH_NUM     = 4;
    localparam int THR_W      = 11;
    localparam int FRAME_W    = 16;
    localparam int BITCNT_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FUNC_W     = 2;

    localparam logic [BITCNT_W-1:0] FRAME_BITS  = BITCNT_W'(16);
    localparam logic [THR_W-1:0]    CMD_LIMIT   = THR_W'(48);
    localparam logic [15:0]         NIBBLE_MASK = 16'h000F;
    localparam logic [FRAME_W-1:0]  FRAME_RESET = 16'h0606;  // frame of throttle 48

    localparam logic [TICK_W-1:0] PERIOD_RESET  = TICK_W'(167);
    localparam logic [TICK_W-1:0] ZERO_HI_RESET = TICK_W'(63);
    localparam logic [TICK_W-1:0] ONE_HI_RESET  = TICK_W'(125);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_LOAD    = 2'd1,
        FUNC_TRIGGER = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_ENABLE = 3'd0,
        CFG_BIT_PERIOD = 3'd1,
        CFG_ZERO_HIGH  = 3'd2,
        CFG_ONE_HIGH   = 3'd3,
        CFG_FRAME_GAP  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEND = 3'b010,
        PH_GAP  = 3'b100
    } phase_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [CH_NUM-1:0] lines;   // bit 0 is channel one
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/dsh_frame_enc.sv
// ----------------------------------------------------------------------------
// dsh_frame_enc
// Builds one 16-bit DShot frame: throttle, telemetry bit and nibble checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsh_frame_enc (
    input  wire logic [dsh_pkg::THR_W-1:0]   throttle,
    output logic      [dsh_pkg::FRAME_W-1:0] frame
);
    import dsh_pkg::*;

    logic        tel_bit;
    logic [11:0] payload;
    logic [11:0] csum_wide;

    // command values get the telemetry request bit
    assign tel_bit   = (throttle != '0) && (throttle < CMD_LIMIT);
    assign payload   = {throttle, tel_bit};
    assign csum_wide = (payload ^ (payload >> 4) ^ (payload >> 8)) & NIBBLE_MASK[11:0];
    assign frame     = {payload, csum_wide[3:0]};

endmodule

`default_nettype wire

FILE: hdl/dsh_core.sv
// ----------------------------------------------------------------------------
// dsh_core
// Configuration registers, frame store and bit cell sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsh_core (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      step,
    input  wire logic [dsh_pkg::FUNC_W-1:0]                func,
    input  wire logic [dsh_pkg::CH_NUM*dsh_pkg::THR_W-1:0] throttles,
    input  wire dsh_pkg::cfg_write_t                       cfg,
    output dsh_pkg::result_t                               result
);
    import dsh_pkg::*;

    logic                run_reg;
    logic [TICK_W-1:0]   period_reg;
    logic [TICK_W-1:0]   zero_hi_reg;
    logic [TICK_W-1:0]   one_hi_reg;
    logic [GAP_W-1:0]    gap_len_reg;

    logic [FRAME_W-1:0]  pending_reg [CH_NUM];
    logic [FRAME_W-1:0]  pending_next [CH_NUM];
    logic [FRAME_W-1:0]  active_reg [CH_NUM];
    logic [FRAME_W-1:0]  active_next [CH_NUM];
    logic [FRAME_W-1:0]  enc_frame [CH_NUM];
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [TICK_W-1:0]   cell_cnt_reg, cell_cnt_next;
    logic [GAP_W-1:0]    gap_cnt_reg, gap_cnt_next;
    phase_t              phase_reg, phase_next;
    logic                done_next;

    logic [TICK_W-1:0]   cell_inc;
    logic [BITCNT_W-1:0] bit_inc;
    logic [GAP_W-1:0]    gap_inc;
    logic                start;

    for (genvar g = 0; g < CH_NUM; g++) begin : g_enc
        dsh_frame_enc u_enc (
            .throttle (throttles[g*THR_W +: THR_W]),
            .frame    (enc_frame[g])
        );
    end

    assign cell_inc = cell_cnt_reg + TICK_W'(1);
    assign bit_inc  = bit_cnt_reg + BITCNT_W'(1);
    assign gap_inc  = gap_cnt_reg + GAP_W'(1);

    always_comb begin
        pending_next  = pending_reg;
        active_next   = active_reg;
        bit_cnt_next  = bit_cnt_reg;
        cell_cnt_next = cell_cnt_reg;
        gap_cnt_next  = gap_cnt_reg;
        phase_next    = phase_reg;
        done_next     = 1'b0;
        start         = 1'b0;

        if (step) begin
            case (func_t'(func))
                FUNC_TICK: begin
                    if (!run_reg) begin
                        phase_next    = PH_IDLE;
                        bit_cnt_next  = '0;
                        cell_cnt_next = '0;
                        gap_cnt_next  = '0;
                    end else if (phase_reg == PH_SEND) begin
                        if (period_reg <= TICK_W'(1) || cell_inc >= period_reg) begin
                            cell_cnt_next = '0;
                            bit_cnt_next  = bit_inc;
                            if (bit_inc >= FRAME_BITS) begin
                                done_next    = 1'b1;
                                bit_cnt_next = '0;
                                gap_cnt_next = '0;
                                phase_next   = (gap_len_reg != '0) ? PH_GAP : PH_IDLE;
                            end
                        end else begin
                            cell_cnt_next = cell_inc;
                        end
                    end else if (phase_reg == PH_GAP) begin
                        if (gap_inc >= gap_len_reg) begin
                            start = 1'b1;
                        end else begin
                            gap_cnt_next = gap_inc;
                        end
                    end
                end
                FUNC_LOAD: begin
                    pending_next = enc_frame;
                end
                FUNC_TRIGGER: begin
                    start = run_reg && (phase_reg != PH_SEND);
                end
                default: begin
                end
            endcase
        end

        if (start) begin
            active_next   = pending_reg;
            phase_next    = PH_SEND;
            bit_cnt_next  = '0;
            cell_cnt_next = '0;
            gap_cnt_next  = '0;
        end

        // enable 0 resets the sequencer; 1 from idle starts the gap
        if (cfg.we && cfg.index == CFG_RUN_ENABLE) begin
            if (!cfg.data[0]) begin
                phase_next    = PH_IDLE;
                bit_cnt_next  = '0;
                cell_cnt_next = '0;
                gap_cnt_next  = '0;
            end else if (phase_reg == PH_IDLE && gap_len_reg != '0) begin
                phase_next   = PH_GAP;
                gap_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= 1'b0;
            period_reg   <= PERIOD_RESET;
            zero_hi_reg  <= ZERO_HI_RESET;
            one_hi_reg   <= ONE_HI_RESET;
            gap_len_reg  <= '0;
            pending_reg  <= '{default: FRAME_RESET};
            active_reg   <= '{default: '0};
            bit_cnt_reg  <= '0;
            cell_cnt_reg <= '0;
            gap_cnt_reg  <= '0;
            phase_reg    <= PH_IDLE;
        end else begin
            pending_reg  <= pending_next;
            active_reg   <= active_next;
            bit_cnt_reg  <= bit_cnt_next;
            cell_cnt_reg <= cell_cnt_next;
            gap_cnt_reg  <= gap_cnt_next;
            phase_reg    <= phase_next;
            if (cfg.we) begin
                case (cfg_idx_t'(cfg.index))
                    CFG_RUN_ENABLE: run_reg     <= cfg.data[0];
                    CFG_BIT_PERIOD: period_reg  <= cfg.data[TICK_W-1:0];
                    CFG_ZERO_HIGH:  zero_hi_reg <= cfg.data[TICK_W-1:0];
                    CFG_ONE_HIGH:   one_hi_reg  <= cfg.data[TICK_W-1:0];
                    CFG_FRAME_GAP:  gap_len_reg <= cfg.data[GAP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // line levels as seen after the item
    always_comb begin
        logic send_on;
        send_on = run_reg && (phase_next == PH_SEND) && (bit_cnt_next < FRAME_BITS);
        for (int i = 0; i < CH_NUM; i++) begin
            if (active_next[i][~bit_cnt_next[3:0]]) begin
                result.lines[i] = send_on && (cell_cnt_next < one_hi_reg);
            end else begin
                result.lines[i] = send_on && (cell_cnt_next < zero_hi_reg);
            end
        end
        result.busy = run_reg && (phase_next == PH_SEND);
        result.done = done_next;
    end

endmodule

`default_nettype wire

FILE: hdl/dshot_four_channel_transmitter.sv
// Inputs pass the input register, then the result register to the master side.
// Throughput: one item per cycle; the input register, sequencer update and
// result register each take one item per clock, stalls come only from m_axis_tready.
// Reset: synchronous, active low; clears both stages, the sequencer (idle) and
// the registers to enable 0, period 167, zero high 63, one high 125, gap 0.
// ----------------------------------------------------------------------------
// dshot_four_channel_transmitter
// Four-channel DShot frame sender with stream input, result and config ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dshot_four_channel_transmitter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // throttle_a [10:0], throttle_b [21:11], throttle_c [32:22], throttle_d [43:33]
    input  wire logic [47:0]                   s_axis_tdata,
    // func [1:0]
    input  wire logic [dsh_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // line_a [0], line_b [1], line_c [2], line_d [3], frame_busy [4], frame_done [5]
    output logic [7:0]                         m_axis_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dsh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dsh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dsh_pkg::*;

    logic                    in_valid_reg;
    logic [FUNC_W-1:0]       in_func_reg;
    logic [CH_NUM*THR_W-1:0] in_thr_reg;
    logic                    out_valid_reg;
    result_t                 out_data_reg;
    result_t                 result;
    cfg_write_t              cfg;
    logic                    fire;

    // advance when the result stage is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign cfg_ready     = 1'b1;

    assign cfg.we    = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_func_reg <= s_axis_tuser;
            in_thr_reg  <= s_axis_tdata[CH_NUM*THR_W-1:0];
        end
    end

    dsh_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .func      (in_func_reg),
        .throttles (in_thr_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

endmodule

`default_nettype wire

FILE: hdl/dsh_checker.sv
// ----------------------------------------------------------------------------
// dsh_checker
// Port-level checks of the DShot transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsh_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // a finished frame leaves the sending phase on the same item
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[4])
        else $error("frame_done reported while still busy");

    // a line may only be high while a frame is being sent
    a_line_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[3:0] != 4'b0000) |-> m_axis_tdata[4])
        else $error("line high outside a frame");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00)
        else $error("padding bits of m_axis_tdata not zero");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result transfer changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind dshot_four_channel_transmitter dsh_checker u_dsh_checker (.*);

`default_nettype wire
